@@ sv/psrl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psrl_pkg
// shared types and constants of the per-source request limiter
// ----------------------------------------------------------------------------
package psrl_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;
  localparam logic [COUNT_W-1:0] COUNT_FIRST = 8'd1;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_REQUEST_LIMIT = 1'b0;

  typedef struct packed {
    logic [ADDR_W-1:0] source_address;
    logic              receive_ok;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [COUNT_W-1:0] request_count;
    logic               accepted;
    logic               new_entry;
  } res_t;

endpackage
`default_nettype wire

@@ sv/psrl_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psrl_front
// takes requests from the command port and hands them to the queue
// ----------------------------------------------------------------------------
module psrl_front
  import psrl_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire req_t      req_i,
  input  wire q_status_t q_status_i,
  output logic           push_o,
  output req_t           push_data_o
);

  logic vld_q, vld_d;
  req_t req_q, req_d;
  logic take;

  assign push_o      = vld_q && !q_status_i.full;
  assign busy        = vld_q && q_status_i.full;
  assign take        = start && !busy;
  assign push_data_o = req_q;

  always_comb begin
    vld_d = vld_q;
    req_d = req_q;
    if (take) begin
      vld_d = 1'b1;
      req_d = req_i;
    end else if (push_o) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

endmodule
`default_nettype wire

@@ sv/psrl_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psrl_fifo
// short request queue between front and back
// ----------------------------------------------------------------------------
module psrl_fifo
  import psrl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire req_t push_data_i,
  input  wire logic pop_i,
  output req_t      head_o,
  output q_status_t status_o
);

  req_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign status_o.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

@@ sv/psrl_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psrl_back
// source table lookup, counter update and result register
// ----------------------------------------------------------------------------
module psrl_back
  import psrl_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire req_t               head_i,
  input  wire q_status_t          q_status_i,
  input  wire logic [COUNT_W-1:0] limit_i,
  output logic                    pop_o,
  output logic                    res_valid_o,
  output res_t                    res_o
);

  logic [ADDR_W-1:0]  keys_q [TABLE_ENTRIES];
  logic [COUNT_W-1:0] cnt_q  [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d, hit;
  logic [IDX_W-1:0]   ptr_q, ptr_d, match_idx, wr_idx;
  logic               hit_any;
  logic [COUNT_W-1:0] cnt_sel, count_d;
  logic               res_valid_q;
  res_t               res_q, res_d;

  assign pop_o = !q_status_i.empty;

  // parallel key compare
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit[i] = valid_q[i] && (keys_q[i] == head_i.source_address);
    end
  end

  always_comb begin
    match_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        match_idx = IDX_W'(i);
      end
    end
  end

  assign hit_any = |hit;
  assign cnt_sel = cnt_q[match_idx];
  assign wr_idx  = hit_any ? match_idx : ptr_q;

  always_comb begin
    if (!hit_any) begin
      count_d = COUNT_FIRST;
    end else if (cnt_sel == COUNT_MAX) begin
      count_d = cnt_sel;
    end else begin
      count_d = cnt_sel + 1'b1;
    end
  end

  always_comb begin
    res_d.request_count = count_d;
    res_d.accepted      = head_i.receive_ok && (count_d <= limit_i);
    res_d.new_entry     = !hit_any;
  end

  always_comb begin
    valid_d = valid_q;
    ptr_d   = ptr_q;
    if (pop_o && !hit_any) begin
      valid_d[ptr_q] = 1'b1;
      ptr_d = (ptr_q == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      ptr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      ptr_q       <= ptr_d;
      res_valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cnt_q[wr_idx] <= count_d;
      if (!hit_any) begin
        keys_q[wr_idx] <= head_i.source_address;
      end
    end
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> $onehot0(hit))
    else $error("several table entries match one source");

  a_result_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> res_valid_q)
    else $error("popped request produced no result");

  a_new_count_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.new_entry) |-> (res_q.request_count == COUNT_FIRST))
    else $error("new entry without a count of one");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.request_count != '0))
    else $error("result count is zero");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= IDX_W'(TABLE_ENTRIES - 1))
    else $error("replace pointer out of range");

endmodule
`default_nettype wire

@@ sv/per_source_request_limiter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_source_request_limiter
// counts requests per source host and flags those within the limit
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low; its
// result appears on the result ports for one cycle, marked by
// result_valid_o, after the input register, the queue and the table stage.
// One request is taken every cycle: the table stage compares all entries in
// parallel and updates one entry per cycle, so busy stays low in operation.
// The receiver cannot stall, so each result must be taken in the cycle it
// is shown. request_limit lies at byte address 0 of the register port. The user
// must write it only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module per_source_request_limiter
  import psrl_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [ADDR_W-1:0]     source_address_i,
  input  wire logic                  receive_ok_i,
  output logic                       result_valid_o,
  output logic [COUNT_W-1:0]         request_count_o,
  output logic                       accepted_o,
  output logic                       new_entry_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [COUNT_W-1:0] limit_q;
  req_t               req_in, push_data, head;
  q_status_t          q_status;
  logic               push, pop;
  res_t               res;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REQUEST_LIMIT) ?
                  APB_DATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_REQUEST_LIMIT)) begin
      limit_q <= pwdata[COUNT_W-1:0];
    end
  end

  assign req_in.source_address = source_address_i;
  assign req_in.receive_ok     = receive_ok_i;

  psrl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_in),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_data_o (push_data)
  );

  psrl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  psrl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .limit_i     (limit_q),
    .pop_o       (pop),
    .res_valid_o (result_valid_o),
    .res_o       (res)
  );

  assign request_count_o = res.request_count;
  assign accepted_o      = res.accepted;
  assign new_entry_o     = res.new_entry;

endmodule
`default_nettype wire
